// File: sv/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// shared constants, codes and types of the sliding door drive controller
// ----------------------------------------------------------------------------
package sdd_pkg;

   // timing of the millisecond tick domain
   localparam int SAMPLE_PERIOD_MS = 20;
   localparam int BLINK_PERIOD_MS  = 1000;
   localparam int TICK_W           = $clog2(BLINK_PERIOD_MS);
   localparam int SAMPLE_W         = (SAMPLE_PERIOD_MS > 1) ? $clog2(SAMPLE_PERIOD_MS) : 1;

   // field widths
   localparam int READING_W  = 24;
   localparam int TIMEOUT_W  = 16;
   localparam int RATE_W     = 30;
   localparam int ELAPSED_W  = 17;
   localparam int PHASE_W    = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 30;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   // load change check
   localparam int CHANGE_SCALE = 50;
   localparam int DIFF_W       = READING_W + 1;
   localparam int SCALE_W      = $clog2(CHANGE_SCALE + 1);
   localparam int PROD_W       = DIFF_W + SCALE_W;

   // register reset values
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000);
   localparam logic [RATE_W-1:0]    RATE_RESET    = RATE_W'(1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE     = 1'd1;

   // door phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_OPEN  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_CLOSE = 2'd2;

   // result of one tick from the door sequencer
   typedef struct packed {
      logic               open_drive;
      logic               close_drive;
      logic [PHASE_W-1:0] door_phase;
   } sdd_drive_type;

endpackage

// File: sv/sdd_door_fsm.sv
// ----------------------------------------------------------------------------
// sdd_door_fsm
// trigger edge detection, move phase, elapsed time and solenoid drive
// ----------------------------------------------------------------------------
module sdd_door_fsm
   import sdd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 trigger_level,
   input  logic                 load_stop,
   input  logic [TIMEOUT_W-1:0] move_timeout_ms,
   output logic                 moving,
   output sdd_drive_type        drive
);

   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic                 prev_trig_ff;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [PHASE_W-1:0]   edge_phase;
   logic [PHASE_W-1:0]   mid_phase;

   always_comb begin
      edge_phase = phase_ff;
      if (trigger_level && !prev_trig_ff) begin
         edge_phase = PH_OPEN;
      end
      if (!trigger_level && prev_trig_ff) begin
         edge_phase = PH_CLOSE;
      end

      drive.open_drive  = 1'b0;
      drive.close_drive = 1'b0;
      if (edge_phase == PH_OPEN || edge_phase == PH_CLOSE) begin
         // saturating count of moving ticks
         elapsed_in = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
         drive.open_drive  = (edge_phase == PH_OPEN);
         drive.close_drive = (edge_phase == PH_CLOSE);
         mid_phase = (elapsed_in > ELAPSED_W'(move_timeout_ms)) ? PH_IDLE : edge_phase;
      end else begin
         elapsed_in = '0;
         mid_phase  = PH_IDLE;
      end

      moving          = (mid_phase != PH_IDLE);
      phase_in        = load_stop ? PH_IDLE : mid_phase;
      drive.door_phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         prev_trig_ff <= 1'b0;
         elapsed_ff   <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         prev_trig_ff <= trigger_level;
         elapsed_ff   <= elapsed_in;
      end
   end

endmodule

// File: sv/sdd_load_monitor.sv
// ----------------------------------------------------------------------------
// sdd_load_monitor
// load cell sampling, change check against threshold and status blink
// ----------------------------------------------------------------------------
module sdd_load_monitor
   import sdd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        cell_ready,
   input  logic signed [READING_W-1:0] cell_reading,
   input  logic [RATE_W-1:0]           max_load_change_rate,
   input  logic                        moving,
   output logic                        load_stop,
   output logic                        status_led
);

   logic [TICK_W-1:0]           tick_ff, tick_in;
   logic [SAMPLE_W-1:0]         sample_ff, sample_in;
   logic signed [READING_W-1:0] newest_ff, newest_in;
   logic signed [READING_W-1:0] older_ff, older_in;
   logic                        newest_vld_ff, newest_vld_in;
   logic                        older_vld_ff, older_vld_in;
   logic                        tick_wrap;
   logic signed [DIFF_W-1:0]    diff;
   logic [DIFF_W-1:0]           abs_diff;
   logic [PROD_W-1:0]           scaled;

   always_comb begin
      // sample slot and blink position of this tick
      tick_wrap = (tick_ff == TICK_W'(BLINK_PERIOD_MS - 1));
      tick_in   = tick_wrap ? '0 : tick_ff + 1'b1;
      if (tick_wrap || sample_ff == SAMPLE_W'(SAMPLE_PERIOD_MS - 1)) begin
         sample_in = '0;
      end else begin
         sample_in = sample_ff + 1'b1;
      end

      newest_in     = newest_ff;
      older_in      = older_ff;
      newest_vld_in = newest_vld_ff;
      older_vld_in  = older_vld_ff;
      if (sample_ff == '0) begin
         older_in      = newest_ff;
         older_vld_in  = newest_vld_ff;
         newest_in     = cell_ready ? cell_reading : '0;
         newest_vld_in = cell_ready;
      end

      diff      = DIFF_W'(newest_in) - DIFF_W'(older_in);
      abs_diff  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      scaled    = PROD_W'(abs_diff) * PROD_W'(CHANGE_SCALE);
      load_stop = moving && newest_vld_in && older_vld_in
                  && (scaled > PROD_W'(max_load_change_rate));

      status_led = !cell_ready && (tick_ff < TICK_W'(BLINK_PERIOD_MS / 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         sample_ff     <= '0;
         newest_ff     <= '0;
         older_ff      <= '0;
         newest_vld_ff <= 1'b1;
         older_vld_ff  <= 1'b1;
      end else if (step) begin
         tick_ff       <= tick_in;
         sample_ff     <= sample_in;
         newest_ff     <= newest_in;
         older_ff      <= older_in;
         newest_vld_ff <= newest_vld_in;
         older_vld_ff  <= older_vld_in;
      end
   end

endmodule

// File: sv/sliding_door_drive_controller.sv
// ----------------------------------------------------------------------------
// sliding_door_drive_controller
// millisecond tick driven door sequencer with load cell change stop
// ----------------------------------------------------------------------------
// path: a request is captured in the input register and its result in the
// result register, which drives rsp_tvalid and holds while rsp_tready is low
// throughput: one tick per cycle, set by the input and result registers
// which advance together whenever the result register is free or taken
// reset: synchronous, clears both pipeline stages and all door state;
// timeout returns to 10000 ms and the change threshold to 1
module sliding_door_drive_controller
   import sdd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel, one transaction per millisecond tick
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // trigger_level[0], cell_reading[24:1], zero
   input  logic                  req_tuser,  // cell_ready[0]
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // open_drive[0], close_drive[1],
                                             // status_led[2], door_phase[4:3], zero
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [RATE_W-1:0]    rate_ff;

   // input stage
   logic                        in_vld_ff, in_vld_in;
   logic                        in_trig_ff;
   logic                        in_ready_ff;
   logic signed [READING_W-1:0] in_reading_ff;

   // result stage
   logic                  out_vld_ff, out_vld_in;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic          advance;
   logic          step;
   logic          moving;
   logic          load_stop;
   logic          status_led;
   sdd_drive_type drive;

   // config is always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         rate_ff    <= RATE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MOVE_TIMEOUT: timeout_ff <= csr_data[TIMEOUT_W-1:0];
            CSR_MAX_RATE:     rate_ff    <= csr_data[RATE_W-1:0];
            default:          ;
         endcase
      end
   end

   // pipeline moves when the result register is empty or being taken
   assign advance    = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = advance ? in_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // capture the tick transaction
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_trig_ff    <= req_tdata[0];
         in_reading_ff <= req_tdata[READING_W:1];
         in_ready_ff   <= req_tuser;
      end
   end

   // door sequencer: edges, elapsed time, drives
   sdd_door_fsm u_door_fsm (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .trigger_level   (in_trig_ff),
      .load_stop       (load_stop),
      .move_timeout_ms (timeout_ff),
      .moving          (moving),
      .drive           (drive)
   );

   // load samples, change stop and status blink
   sdd_load_monitor u_load_monitor (
      .clock                (clock),
      .reset                (reset),
      .step                 (step),
      .cell_ready           (in_ready_ff),
      .cell_reading         (in_reading_ff),
      .max_load_change_rate (rate_ff),
      .moving               (moving),
      .load_stop            (load_stop),
      .status_led           (status_led)
   );

   // result register, payload loads on each processed tick
   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= {3'b000, drive.door_phase, status_led,
                         drive.close_drive, drive.open_drive};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: sv/sdd_checker.sv
// ----------------------------------------------------------------------------
// sdd_checker
// port level checks on the result channel of the door controller
// ----------------------------------------------------------------------------
module sdd_checker
   import sdd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // never both solenoids
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("both solenoids driven");

   // a phase still opening after the tick drove the open solenoid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:3] == PH_OPEN |-> rsp_tdata[0])
      else $error("opening without open drive");

   // a phase still closing after the tick drove the close solenoid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:3] == PH_CLOSE |-> rsp_tdata[1])
      else $error("closing without close drive");

endmodule

bind sliding_door_drive_controller sdd_checker u_sdd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
